### rtl/core/voxel_ray_traversal_unit_assert.svh
// Assertion macros for the voxel ray traversal unit
`ifndef VOXEL_RAY_TRAVERSAL_UNIT_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_UNIT_ASSERT_SVH

// same-cycle implication
`define VRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared constants for the voxel ray traversal unit.
// ----------------------------------------------------------------------------
package vrt_pkg;

   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 200;
   localparam int CSR_ADDR_W = 5;
   localparam int DIV_BITS   = 29;   // quotient bits of 2^28 / |dir|

   localparam logic OP_START  = 1'b0;
   localparam logic OP_ANSWER = 1'b1;

   localparam logic [2:0] KIND_QUERY = 3'd0;
   localparam logic [2:0] KIND_HIT   = 3'd1;
   localparam logic [2:0] KIND_LEFT  = 3'd2;
   localparam logic [2:0] KIND_LIMIT = 3'd3;
   localparam logic [2:0] KIND_NONE  = 3'd4;

   localparam logic [2:0] REG_MIN_X = 3'd0;
   localparam logic [2:0] REG_MIN_Y = 3'd1;
   localparam logic [2:0] REG_MIN_Z = 3'd2;
   localparam logic [2:0] REG_MAX_X = 3'd3;
   localparam logic [2:0] REG_MAX_Y = 3'd4;
   localparam logic [2:0] REG_MAX_Z = 3'd5;

   localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;
   localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

   localparam logic [1:0] NORMAL_POS = 2'b01;
   localparam logic [1:0] NORMAL_NEG = 2'b11;

endpackage

### rtl/core/voxel_ray_traversal_unit.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_unit
// 3D grid ray stepper: one request per ray start or occupancy answer, one
// response per request.
// ----------------------------------------------------------------------------
// A start request runs one reciprocal division per nonzero axis on one shared
// restoring divider (a setup state for every axis, then a divide and a multiply
// state for each nonzero axis) and then an advance step before its response;
// an answer for an empty voxel runs an advance step, and an answer for an
// occupied voxel uses the shared 16x32 multiplier once per axis for the hit point. One
// request is in work at a time; req_tready is low while a request is in work
// or a response is waiting.
`include "voxel_ray_traversal_unit_assert.svh"

module voxel_ray_traversal_unit import vrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance,
   // occupied, voxel_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,   // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // voxel_x, voxel_y, voxel_z, normal_x, normal_y, normal_z, distance,
   // hit_x, hit_y, hit_z, hit_value, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,   // kind
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_DIV, ST_BMUL, ST_ADV, ST_HMUL, ST_HADD
   } state_type;

   state_type          state_ff;
   logic               rsp_valid_ff;
   logic               active_ff;
   logic signed [15:0] bmin_ff [3];
   logic signed [15:0] bmax_ff [3];
   logic signed [31:0] org_ff  [3];
   logic signed [15:0] dir_ff  [3];
   logic signed [15:0] cell_ff [3];
   logic [31:0]        bnd_ff  [3];
   logic [31:0]        step_ff [3];
   logic [2:0]         neg_ff;
   logic [1:0]         last_axis_ff;
   logic [31:0]        trav_ff;
   logic [30:0]        limit_ff;
   logic [1:0]         ax_ff;
   logic [4:0]         cnt_ff;
   logic [15:0]        rem_ff;
   logic [DIV_BITS-1:0] q_ff;
   logic signed [47:0] prod_ff;
   logic signed [31:0] hit_ff [3];
   logic [15:0]        vval_ff;

   logic [2:0]         kind_ff;
   logic [15:0]        ovox_ff [3];
   logic [1:0]         onorm_ff [3];
   logic [30:0]        odist_ff;
   logic [31:0]        ohit_ff [3];
   logic [15:0]        oval_ff;

   logic req_fire, csr_wr;
   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // request fields
   logic signed [31:0] req_org [3];
   logic signed [15:0] req_dir [3];
   assign req_org[0] = req_tdata[31:0];
   assign req_org[1] = req_tdata[63:32];
   assign req_org[2] = req_tdata[95:64];
   assign req_dir[0] = req_tdata[111:96];
   assign req_dir[1] = req_tdata[127:112];
   assign req_dir[2] = req_tdata[143:128];

   // divider step
   logic signed [15:0] cur_dir;
   logic signed [16:0] dir_wide;
   logic [16:0]        mag_wide;
   logic [15:0]        mag;
   logic [16:0]        div_r;
   logic               div_ge;
   logic [15:0]        rem_in;
   logic [DIV_BITS-1:0] q_in;
   logic [15:0]        frac;
   logic [16:0]        fdist;
   logic [45:0]        bprod;

   always_comb begin
      cur_dir  = dir_ff[ax_ff];
      dir_wide = {cur_dir[15], cur_dir};
      mag_wide = cur_dir[15] ? 17'(-dir_wide) : 17'(dir_wide);
      mag      = mag_wide[15:0];
      div_r    = {rem_ff, (cnt_ff == 5'(DIV_BITS - 1))};
      div_ge   = div_r >= {1'b0, mag};
      rem_in   = div_ge ? 16'(div_r - {1'b0, mag}) : div_r[15:0];
      q_in     = {q_ff[DIV_BITS-2:0], div_ge};
      frac     = org_ff[ax_ff][15:0];
      fdist    = (!cur_dir[15] && cur_dir != 16'sd0) ? 17'(17'h10000 - {1'b0, frac})
                                                     : {1'b0, frac};
      bprod    = 46'(fdist) * 46'(q_ff);
   end

   // step selection and bounds check
   logic [1:0]         sel_axis;
   logic [31:0]        bnd_sum;
   logic [32:0]        bnd_wide;
   logic signed [16:0] next_pos [3];
   logic               in_box;

   always_comb begin
      if (bnd_ff[0] < bnd_ff[1] && bnd_ff[0] < bnd_ff[2]) sel_axis = 2'd0;
      else if (bnd_ff[1] < bnd_ff[2])                     sel_axis = 2'd1;
      else                                                sel_axis = 2'd2;
      bnd_wide = {1'b0, bnd_ff[sel_axis]} + {1'b0, step_ff[sel_axis]};
      bnd_sum  = bnd_wide[32] ? SAT32 : bnd_wide[31:0];
      in_box   = 1'b1;
      for (int i = 0; i < 3; i++) begin
         next_pos[i] = {cell_ff[i][15], cell_ff[i]};
         if (2'(i) == sel_axis)
            next_pos[i] = neg_ff[i] ? next_pos[i] - 17'sd1 : next_pos[i] + 17'sd1;
         if (next_pos[i] < $signed({bmin_ff[i][15], bmin_ff[i]}) ||
             next_pos[i] > $signed({bmax_ff[i][15], bmax_ff[i]}))
            in_box = 1'b0;
      end
   end

   // hit point
   logic [30:0]        trav_sat;
   logic signed [47:0] hprod;
   logic signed [36:0] hsum;
   logic signed [31:0] hsat;

   always_comb begin
      trav_sat = trav_ff[31] ? DIST_MAX : trav_ff[30:0];
      hprod    = 48'(cur_dir) * 48'($signed({1'b0, trav_sat}));
      hsum     = {{5{org_ff[ax_ff][31]}}, org_ff[ax_ff]} + {prod_ff[47], prod_ff[47:12]};
      if (hsum[36:31] == 6'b000000 || hsum[36:31] == 6'b111111) hsat = hsum[31:0];
      else if (hsum[36])                                         hsat = 32'sh8000_0000;
      else                                                       hsat = 32'sh7FFF_FFFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            bmin_ff[i] <= -16'sd1000;
            bmax_ff[i] <= 16'sd1000;
         end
      end else begin
         if (csr_wr) begin
            case (csr_paddr[4:2])
               REG_MIN_X: bmin_ff[0] <= csr_pwdata[15:0];
               REG_MIN_Y: bmin_ff[1] <= csr_pwdata[15:0];
               REG_MIN_Z: bmin_ff[2] <= csr_pwdata[15:0];
               REG_MAX_X: bmax_ff[0] <= csr_pwdata[15:0];
               REG_MAX_Y: bmax_ff[1] <= csr_pwdata[15:0];
               REG_MAX_Z: bmax_ff[2] <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  ax_ff <= 2'd0;
                  if (req_tuser[0] == OP_START) begin
                     for (int i = 0; i < 3; i++) begin
                        org_ff[i] <= req_org[i];
                        dir_ff[i] <= req_dir[i];
                     end
                     limit_ff     <= req_tdata[174:144];
                     trav_ff      <= '0;
                     last_axis_ff <= 2'd0;
                     active_ff    <= 1'b1;
                     state_ff     <= ST_SETUP;
                  end else if (!active_ff) begin
                     kind_ff  <= KIND_NONE;
                     odist_ff <= '0;
                     oval_ff  <= '0;
                     for (int i = 0; i < 3; i++) begin
                        ovox_ff[i]  <= '0;
                        onorm_ff[i] <= '0;
                        ohit_ff[i]  <= '0;
                     end
                     rsp_valid_ff <= 1'b1;
                  end else if (req_tdata[175]) begin
                     vval_ff  <= req_tdata[191:176];
                     state_ff <= ST_HMUL;
                  end else begin
                     state_ff <= ST_ADV;
                  end
               end
            end
            ST_SETUP: begin
               cell_ff[ax_ff] <= org_ff[ax_ff][31:16];
               neg_ff[ax_ff]  <= cur_dir[15] || (cur_dir == 16'sd0);
               if (mag == 16'd0) begin
                  step_ff[ax_ff] <= SAT32;
                  bnd_ff[ax_ff]  <= SAT32;
                  ax_ff          <= ax_ff + 2'd1;
                  state_ff       <= (ax_ff == 2'd2) ? ST_ADV : ST_SETUP;
               end else begin
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  cnt_ff   <= 5'(DIV_BITS - 1);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               q_ff   <= q_in;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) state_ff <= ST_BMUL;
            end
            ST_BMUL: begin
               step_ff[ax_ff] <= 32'(q_ff);
               bnd_ff[ax_ff]  <= 32'(bprod[45:16]);
               ax_ff          <= ax_ff + 2'd1;
               state_ff       <= (ax_ff == 2'd2) ? ST_ADV : ST_SETUP;
            end
            ST_ADV: begin
               oval_ff <= '0;
               for (int i = 0; i < 3; i++) ohit_ff[i] <= '0;
               if (trav_ff >= {1'b0, limit_ff}) begin
                  kind_ff   <= KIND_LIMIT;
                  active_ff <= 1'b0;
                  odist_ff  <= trav_sat;
                  for (int i = 0; i < 3; i++) begin
                     ovox_ff[i]  <= cell_ff[i];
                     onorm_ff[i] <= '0;
                  end
               end else begin
                  trav_ff          <= bnd_ff[sel_axis];
                  odist_ff         <= bnd_ff[sel_axis][31] ? DIST_MAX
                                                           : bnd_ff[sel_axis][30:0];
                  bnd_ff[sel_axis] <= bnd_sum;
                  last_axis_ff     <= sel_axis;
                  for (int i = 0; i < 3; i++) begin
                     ovox_ff[i]  <= next_pos[i][15:0];
                     onorm_ff[i] <= (2'(i) == sel_axis)
                                    ? (neg_ff[i] ? NORMAL_POS : NORMAL_NEG) : 2'b00;
                  end
                  if (in_box) begin
                     kind_ff           <= KIND_QUERY;
                     cell_ff[sel_axis] <= next_pos[sel_axis][15:0];
                  end else begin
                     kind_ff   <= KIND_LEFT;
                     active_ff <= 1'b0;
                  end
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_HMUL: begin
               prod_ff  <= hprod;
               state_ff <= ST_HADD;
            end
            ST_HADD: begin
               hit_ff[ax_ff] <= hsat;
               ax_ff         <= ax_ff + 2'd1;
               state_ff      <= (ax_ff == 2'd2) ? ST_IDLE : ST_HMUL;
               if (ax_ff == 2'd2) begin
                  kind_ff   <= KIND_HIT;
                  active_ff <= 1'b0;
                  odist_ff  <= trav_sat;
                  oval_ff   <= vval_ff;
                  for (int i = 0; i < 3; i++) begin
                     ovox_ff[i]  <= cell_ff[i];
                     onorm_ff[i] <= (2'(i) == last_axis_ff)
                                    ? (neg_ff[i] ? NORMAL_POS : NORMAL_NEG) : 2'b00;
                  end
                  ohit_ff[0]   <= hit_ff[0];
                  ohit_ff[1]   <= hit_ff[1];
                  ohit_ff[2]   <= hsat;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_MIN_X: csr_prdata = 32'(bmin_ff[0]);
         REG_MIN_Y: csr_prdata = 32'(bmin_ff[1]);
         REG_MIN_Z: csr_prdata = 32'(bmin_ff[2]);
         REG_MAX_X: csr_prdata = 32'(bmax_ff[0]);
         REG_MAX_Y: csr_prdata = 32'(bmax_ff[1]);
         REG_MAX_Z: csr_prdata = 32'(bmax_ff[2]);
         default:   csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {3'b000, oval_ff, ohit_ff[2], ohit_ff[1], ohit_ff[0], odist_ff,
                        onorm_ff[2], onorm_ff[1], onorm_ff[0],
                        ovox_ff[2], ovox_ff[1], ovox_ff[0]};

   `VRT_ASSERT_NOW(a_ready_not_pending, clock, reset, req_tready, !rsp_valid_ff,
                   "request taken while a response is pending")
   `VRT_ASSERT_NEXT(a_start_busy, clock, reset, req_fire && req_tuser[0] == OP_START,
                    !req_tready && active_ff, "start request did not begin a ray")
   `VRT_ASSERT_NOW(a_one_normal, clock, reset,
                   rsp_valid_ff && (kind_ff == KIND_QUERY || kind_ff == KIND_HIT ||
                                    kind_ff == KIND_LEFT),
                   $countones({onorm_ff[0] != 2'b00, onorm_ff[1] != 2'b00,
                               onorm_ff[2] != 2'b00}) == 1,
                   "crossed face normal is not on exactly one axis")
   `VRT_ASSERT_NOW(a_none_idle, clock, reset,
                   rsp_valid_ff && kind_ff == KIND_NONE, !active_ff && odist_ff == '0,
                   "no-ray response with a ray active")

endmodule

### tb/sv/tb_voxel_ray_traversal_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_ray_traversal_unit
// Self-checking bench for the voxel ray stepper: drives ray starts and
// occupancy answers, predicts each response in a local model of the DDA walk
// and compares every response field against it.
// ----------------------------------------------------------------------------
import vrt_pkg::*;

typedef struct packed {
   logic [2:0]  kind;
   logic [15:0] vox_x, vox_y, vox_z;
   logic [1:0]  nrm_x, nrm_y, nrm_z;
   logic [30:0] dval;
   logic [31:0] hit_x, hit_y, hit_z;
   logic [15:0] hval;
} ray_rsp_type;

class ray_scoreboard;
   int          errors;
   int          bmin[3];
   int          bmax[3];
   bit          ray_active;
   int          cur_vox[3];
   longint      bdist[3];
   longint      step_len[3];
   bit          step_neg[3];
   int          last_axis;
   longint      travelled;
   longint      limit;
   int          origin[3];
   int          dir[3];
   ray_rsp_type pending[$];

   function new();
      for (int i = 0; i < 3; i++) begin
         bmin[i] = -1000; bmax[i] = 1000;
         cur_vox[i] = 0; bdist[i] = 0; step_len[i] = 0; step_neg[i] = 0;
         origin[i] = 0; dir[i] = 0;
      end
      ray_active = 0; last_axis = 0; travelled = 0; limit = 0; errors = 0;
   endfunction

   function ray_rsp_type make_rsp(logic [2:0] kind, int v[3], bit with_normal);
      ray_rsp_type r;
      r = '0;
      r.kind = kind;
      r.vox_x = v[0][15:0]; r.vox_y = v[1][15:0]; r.vox_z = v[2][15:0];
      if (with_normal) begin
         case (last_axis)
            0: r.nrm_x = step_neg[0] ? NORMAL_POS : NORMAL_NEG;
            1: r.nrm_y = step_neg[1] ? NORMAL_POS : NORMAL_NEG;
            default: r.nrm_z = step_neg[2] ? NORMAL_POS : NORMAL_NEG;
         endcase
      end
      r.dval = (travelled > longint'(DIST_MAX)) ? DIST_MAX : travelled[30:0];
      return r;
   endfunction

   function ray_rsp_type walk_step();
      int  a;
      int  nxt[3];
      bit  in_box;
      if (travelled >= limit) begin
         ray_active = 0;
         return make_rsp(KIND_LIMIT, cur_vox, 0);
      end
      if (bdist[0] < bdist[1] && bdist[0] < bdist[2]) a = 0;
      else if (bdist[1] < bdist[2]) a = 1;
      else a = 2;
      travelled = bdist[a];
      bdist[a] = bdist[a] + step_len[a];
      if (bdist[a] > longint'(SAT32)) bdist[a] = SAT32;
      last_axis = a;
      nxt = cur_vox;
      nxt[a] += step_neg[a] ? -1 : 1;
      in_box = 1;
      for (int i = 0; i < 3; i++)
         if (nxt[i] < bmin[i] || nxt[i] > bmax[i]) in_box = 0;
      if (!in_box) begin
         ray_active = 0;
         return make_rsp(KIND_LEFT, nxt, 1);
      end
      cur_vox[a] = nxt[a];
      return make_rsp(KIND_QUERY, cur_vox, 1);
   endfunction

   function logic [31:0] hit_point(int org, int d, longint tval);
      longint p, q, r;
      p = longint'(d) * tval;
      if (p >= 0) q = p >>> 12;
      else q = -(((-p) + 4095) >>> 12);
      r = longint'(org) + q;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // accepted request: update the walk and queue the response it causes
   function void note_request(logic op, logic [REQ_DATA_W-1:0] d);
      ray_rsp_type r;
      longint      mag, f, p, hdist;
      if (op == OP_START) begin
         for (int a = 0; a < 3; a++) begin
            origin[a] = d[32*a +: 32];
            dir[a] = $signed(d[96 + 16*a +: 16]);
            mag = (dir[a] < 0) ? -dir[a] : dir[a];
            cur_vox[a] = $signed(d[32*a + 16 +: 16]);
            step_neg[a] = !(dir[a] > 0);
            if (mag == 0) begin
               step_len[a] = SAT32; bdist[a] = SAT32;
            end else begin
               f = (dir[a] > 0) ? 65536 - d[32*a +: 16] : d[32*a +: 16];
               step_len[a] = (64'd1 << 28) / mag;
               p = (f * step_len[a]) >>> 16;
               bdist[a] = (p > longint'(SAT32)) ? SAT32 : p;
            end
         end
         limit = d[144 +: 31];
         travelled = 0; last_axis = 0; ray_active = 1;
         r = walk_step();
      end else if (!ray_active) begin
         r = '0;
         r.kind = KIND_NONE;
      end else if (d[175]) begin
         ray_active = 0;
         r = make_rsp(KIND_HIT, cur_vox, 1);
         hdist = r.dval;
         r.hit_x = hit_point(origin[0], dir[0], hdist);
         r.hit_y = hit_point(origin[1], dir[1], hdist);
         r.hit_z = hit_point(origin[2], dir[2], hdist);
         r.hval = d[176 +: 16];
      end else begin
         r = walk_step();
      end
      pending.insert(pending.size(), r);
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_response(logic [2:0] kind, logic [RSP_DATA_W-1:0] d);
      ray_rsp_type e, g;
      g.kind = kind;
      g.vox_x = d[0 +: 16]; g.vox_y = d[16 +: 16]; g.vox_z = d[32 +: 16];
      g.nrm_x = d[48 +: 2]; g.nrm_y = d[50 +: 2]; g.nrm_z = d[52 +: 2];
      g.dval = d[54 +: 31];
      g.hit_x = d[85 +: 32]; g.hit_y = d[117 +: 32]; g.hit_z = d[149 +: 32];
      g.hval = d[181 +: 16];
      if (pending.size() == 0) begin
         report($sformatf("unexpected response kind %0d", kind));
      end else begin
         e = pending.pop_front();
         if (g.kind != e.kind) report($sformatf("kind %0d exp %0d", g.kind, e.kind));
         if (g.vox_x != e.vox_x) report($sformatf("voxel_x %h exp %h", g.vox_x, e.vox_x));
         if (g.vox_y != e.vox_y) report($sformatf("voxel_y %h exp %h", g.vox_y, e.vox_y));
         if (g.vox_z != e.vox_z) report($sformatf("voxel_z %h exp %h", g.vox_z, e.vox_z));
         if (g.nrm_x != e.nrm_x) report($sformatf("normal_x %b exp %b", g.nrm_x, e.nrm_x));
         if (g.nrm_y != e.nrm_y) report($sformatf("normal_y %b exp %b", g.nrm_y, e.nrm_y));
         if (g.nrm_z != e.nrm_z) report($sformatf("normal_z %b exp %b", g.nrm_z, e.nrm_z));
         if (g.dval != e.dval) report($sformatf("distance %h exp %h", g.dval, e.dval));
         if (g.hit_x != e.hit_x) report($sformatf("hit_x %h exp %h", g.hit_x, e.hit_x));
         if (g.hit_y != e.hit_y) report($sformatf("hit_y %h exp %h", g.hit_y, e.hit_y));
         if (g.hit_z != e.hit_z) report($sformatf("hit_z %h exp %h", g.hit_z, e.hit_z));
         if (g.hval != e.hval) report($sformatf("hit_value %h exp %h", g.hval, e.hval));
      end
   endtask
endclass

module tb_voxel_ray_traversal_unit;

   localparam int CYCLE_LIMIT = 2000000;

   logic                  clock = 0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   ray_scoreboard sb = new();
   int            idle_pct;
   int            stall_pct;
   int            cycles;

   voxel_ray_traversal_unit u_top (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("voxel_ray_traversal_unit regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task send_request(logic op, logic [REQ_DATA_W-1:0] d);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, d);
   endtask

   task csr_write(logic [2:0] idx, logic [15:0] v);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= {{16{v[15]}}, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
      if (idx < 3) sb.bmin[idx] = $signed(v);
      else sb.bmax[idx - 3] = $signed(v);
   endtask

   task set_box(int x0, int y0, int z0, int x1, int y1, int z1);
      csr_write(REG_MIN_X, x0[15:0]); csr_write(REG_MIN_Y, y0[15:0]);
      csr_write(REG_MIN_Z, z0[15:0]); csr_write(REG_MAX_X, x1[15:0]);
      csr_write(REG_MAX_Y, y1[15:0]); csr_write(REG_MAX_Z, z1[15:0]);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function logic [REQ_DATA_W-1:0] pack_req(logic [31:0] ox, oy, oz,
         logic [15:0] dx, dy, dz, logic [30:0] maxd, logic occ, logic [15:0] val);
      return {val, occ, maxd, dz, dy, dx, oz, oy, ox};
   endfunction

   function logic [15:0] rand_dir();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'($urandom);
         2: return 16'($urandom_range(4096, 1)) * (($urandom_range(1)) ? 16'h0001 : 16'hFFFF);
         default: return 16'($urandom_range(16384, 1)) * (($urandom_range(1)) ? 16'h0001 : 16'hFFFF);
      endcase
   endfunction

   function logic [31:0] rand_origin();
      if ($urandom_range(9) == 0) return $urandom;
      return {16'($urandom_range(12)) - 16'd6, 16'($urandom)};
   endfunction

   task start_random_ray();
      logic [30:0] maxd;
      maxd = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(20 * 65536));
      send_request(OP_START, pack_req(rand_origin(), rand_origin(), rand_origin(),
                   rand_dir(), rand_dir(), rand_dir(), maxd, 1'b0, 16'h0));
   endtask

   // mostly well-formed walks: start, answer queries, with some noise mixed in
   task run_rays(int n, bit hold_off);
      logic [REQ_DATA_W-1:0] d;
      for (int i = 0; i < n; i++) begin
         if (hold_off && i == n / 2) begin
            req_tvalid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
         if ($urandom_range(19) == 0) begin
            for (int w = 0; w < REQ_DATA_W; w += 32) d[w +: 32] = $urandom;
            send_request(1'($urandom), d);
         end else if (!sb.ray_active || $urandom_range(49) == 0) begin
            start_random_ray();
         end else begin
            d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            d[175] = ($urandom_range(99) < 12);
            send_request(OP_ANSWER, d);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = OP_START;
      rsp_tready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      idle_pct = 0; stall_pct = 0; cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b1, 16'hFFFF));
      send_request(OP_START, pack_req(0, 0, 0, 16'h1000, 0, 0, 31'h0, 0, 0));
      send_request(OP_START, pack_req(0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0));
      send_request(OP_START, pack_req(32'h0000_8000, 32'h0001_4000, 32'hFFFF_C000,
                   16'h1000, 16'h1000, 16'h1000, 31'h7FFF_FFFF, 0, 0));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b0, 0));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b0, 0));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b1, 16'hFFFF));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b1, 16'h1234));
      send_request(OP_START, pack_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                   16'h8000, 16'h7FFF, 16'h0001, 31'h7FFF_FFFF, 0, 0));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b0, 0));
      send_request(OP_START, pack_req(32'h03E7_FFFF, 0, 0, 16'h7FFF, 0, 0,
                   31'h7FFF_FFFF, 0, 0));
      send_request(OP_START, pack_req(32'h0000_0001, 32'hFFFF_FFFF, 0,
                   16'hFFFF, 16'h0001, 16'h8000, 31'h0010_0000, 0, 0));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b0, 0));
      send_request(OP_START, pack_req(0, 0, 0, 16'h0800, 16'h0800, 0, 31'h0003_0000, 0, 0));
      send_request(OP_START, pack_req(0, 0, 0, 16'h2000, 0, 0, 31'h0004_0000, 0, 0));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b0, 0));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b0, 0));
      send_request(OP_ANSWER, pack_req(0, 0, 0, 0, 0, 0, 0, 1'b1, 16'h00FF));
      drain();

      // empty box, then a tight box
      set_box(5, 5, 5, -5, -5, -5);
      send_request(OP_START, pack_req(0, 0, 0, 16'h1000, 16'h0400, 0, 31'h7FFF_FFFF, 0, 0));
      send_request(OP_START, pack_req(0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0));
      drain();
      set_box(-3, -3, -3, 3, 3, 3);
      run_rays(130, 1'b0);
      drain();

      idle_pct = 54; stall_pct = 0;
      set_box(-32768, -32768, -32768, 32767, 32767, 32767);
      run_rays(130, 1'b1);
      drain();

      idle_pct = 0; stall_pct = 54;
      set_box(0, 0, 0, 0, 0, 0);
      run_rays(130, 1'b0);
      drain();

      idle_pct = 26; stall_pct = 26;
      set_box(-6, -4, -8, 7, 5, 2);
      run_rays(130, 1'b0);
      drain();

      idle_pct = 0; stall_pct = 0;
      set_box(-1000, -1000, -1000, 1000, 1000, 1000);
      run_rays(130, 1'b0);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("voxel_ray_traversal_unit regression: pass");
      else
         $display("voxel_ray_traversal_unit regression: fail");
      $finish;
   end

endmodule

### voxel_ray_traversal_unit.f
+incdir+rtl/core
rtl/core/vrt_pkg.sv
rtl/core/voxel_ray_traversal_unit.sv
tb/sv/tb_voxel_ray_traversal_unit.sv
